// ===== src/rprd_pkg.sv =====
package rprd_pkg;

  localparam int ADDR_BITS = 8;
  localparam logic [15:0] ADDR_MASK =
    (ADDR_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << ADDR_BITS) - 32'd1);

  localparam int WORD_W   = 16;
  localparam int REG_W    = 8;
  localparam int REPEAT_W = 15;
  localparam int OUT_W    = 40;

  typedef enum logic [3:0] {
    PH_ADDR  = 4'b0001,
    PH_COUNT = 4'b0010,
    PH_RUN   = 4'b0100,
    PH_COPY  = 4'b1000
  } phase_t;

endpackage

// ===== src/register_patch_rle_decoder_top.sv =====
// Decodes a stream of 16-bit patch words into register writes. Each record is an
// address word, then a count word; a count with bit 15 set is a run whose one value
// word gives a single write carrying the 15-bit repeat count (no write if it is zero),
// and otherwise the count says how many value words follow, each giving a write with
// repeat count 1. A word with the start flag set is always taken as a record address.
// The block takes one word every cycle; each word passes through a small phase machine
// into one output register, so a write appears in the cycle after its value word is
// taken, and the input stalls only while that register holds a result not yet taken.
module register_patch_rle_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] patch_word
  input  logic [0:0]  s_axis_tuser,   // [0] record_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [7:0] reg_address, [23:8] write_value,
                                      // [38:24] repeat_count, [39] zero
);

  rprd_pkg::phase_t                    phase, phase_next, phase_eff;
  logic [rprd_pkg::REG_W-1:0]          held_address, held_address_next;
  logic [rprd_pkg::REPEAT_W-1:0]       words_left, words_left_next;
  logic [rprd_pkg::REPEAT_W-1:0]       words_dec;
  logic                                emit;
  logic [rprd_pkg::REPEAT_W-1:0]       emit_repeat;
  logic                                accept;
  logic [rprd_pkg::WORD_W-1:0]         word;
  logic [rprd_pkg::WORD_W-1:0]         masked_addr;

  assign word          = s_axis_tdata;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign words_dec     = words_left - 15'd1;
  assign masked_addr   = word & rprd_pkg::ADDR_MASK;

  always_comb begin
    phase_eff         = s_axis_tuser[0] ? rprd_pkg::PH_ADDR : phase;
    phase_next        = phase_eff;
    held_address_next = held_address;
    words_left_next   = words_left;
    emit              = 1'b0;
    emit_repeat       = 15'd1;
    unique case (phase_eff)
      rprd_pkg::PH_ADDR: begin
        held_address_next = masked_addr[rprd_pkg::REG_W-1:0];
        phase_next        = rprd_pkg::PH_COUNT;
      end
      rprd_pkg::PH_COUNT: begin
        words_left_next = word[14:0];
        if (word[15]) begin
          phase_next = rprd_pkg::PH_RUN;
        end else if (word[14:0] != 15'd0) begin
          phase_next = rprd_pkg::PH_COPY;
        end else begin
          phase_next = rprd_pkg::PH_ADDR;
        end
      end
      rprd_pkg::PH_RUN: begin
        phase_next      = rprd_pkg::PH_ADDR;
        emit            = (words_left != 15'd0);
        emit_repeat     = words_left;
        words_left_next = 15'd0;
      end
      rprd_pkg::PH_COPY: begin
        emit            = 1'b1;
        words_left_next = words_dec;
        if (words_dec == 15'd0) begin
          phase_next = rprd_pkg::PH_ADDR;
        end
      end
      default: begin
        phase_next = rprd_pkg::PH_ADDR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= rprd_pkg::PH_ADDR;
      held_address  <= '0;
      words_left    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        held_address  <= held_address_next;
        words_left    <= words_left_next;
        m_axis_tvalid <= emit;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      m_axis_tdata <= {1'b0, emit_repeat, word, held_address};
    end
  end

endmodule

// ===== src/rprd_checker.sv =====
module rprd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  localparam int RC_LO = rprd_pkg::REG_W + rprd_pkg::WORD_W;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("Output word valid right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled output word changed.");

  a_repeat_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[RC_LO+rprd_pkg::REPEAT_W-1:RC_LO] != 15'd0)
    else $error("Output word carries a zero repeat count.");

  a_start_silent: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> !m_axis_tvalid)
    else $error("Address word produced an output word.");

endmodule

bind register_patch_rle_decoder_top rprd_checker u_rprd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
